// File: hw/rtl/stp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_pkg
// Types and constants shared by the stepper profiler.
// ----------------------------------------------------------------------------
package stp_pkg;

  localparam int RATE_W  = 20;
  localparam int DIST_W  = 24;
  localparam int ACC_W   = 17;
  localparam int ACCEL_W = 16;
  localparam int POS_W   = 32;

  localparam logic [RATE_W-1:0]  RATE_MAX    = 20'hFFFFF;
  localparam logic [RATE_W-1:0]  SSS_RESET   = 20'd100;
  localparam logic [ACCEL_W-1:0] ACCEL_RESET = 16'd10;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_START_STOP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL      = 1'd1;

  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_SUBMIT = 2'd1;
  localparam logic [1:0] MODE_PLAN   = 2'd2;

  // divider: numerator up to distance * rate, denominator up to two rates
  localparam int DIV_NW = 44;
  localparam int DIV_DW = 21;
  localparam int DIV_CW = 6;

  typedef struct packed {
    logic [1:0]        mode;
    logic              block_dir;
    logic [DIST_W-1:0] block_distance;
    logic [RATE_W-1:0] block_speed;
    logic              brake;
    logic              enable;
  } in_item_t;

  typedef struct packed {
    logic                    pulse_level;
    logic                    dir_level;
    logic                    drive_enable;
    logic [RATE_W-1:0]       step_rate;
    logic                    running;
    logic signed [POS_W-1:0] position;
    logic                    accepted;
    logic                    timer_start;
  } out_item_t;

  typedef struct packed {
    logic              dir;
    logic [DIST_W-1:0] pulses;
    logic [RATE_W-1:0] speed;
  } blk_t;

  typedef struct packed {
    logic                    dir;
    logic signed [ACC_W-1:0] acc;
    logic [DIST_W-1:0]       pulses;
  } seg_t;

endpackage

// File: hw/rtl/stp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_div
// Restoring divider, one quotient bit per cycle. Zero divisor gives zero.
// ----------------------------------------------------------------------------
module stp_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [stp_pkg::DIV_NW-1:0] num,
  input  logic [stp_pkg::DIV_DW-1:0] den,
  output logic                       done,
  output logic [stp_pkg::DIV_NW-1:0] quo
);
  import stp_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_NW-1:0] num_r;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_DW-1:0] rem_r;
  logic              zero_r;
  logic [DIV_DW:0]   rem_sh;
  logic              ge;
  logic [DIV_DW-1:0] rem_nxt;

  assign rem_sh  = {rem_r, num_r[DIV_NW-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_nxt = ge ? DIV_DW'(rem_sh - {1'b0, den_r}) : rem_sh[DIV_DW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CW'(DIV_NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r  <= num;
      den_r  <= den;
      rem_r  <= '0;
      zero_r <= (den == '0);
    end else if (busy_r) begin
      num_r <= {num_r[DIV_NW-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = zero_r ? '0 : num_r;

endmodule

// File: hw/rtl/stepper_trapezoid_planner_pulser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_trapezoid_planner_pulser
// Single-axis stepper profiler: block queue, planner, segment queue, pulser.
// ----------------------------------------------------------------------------
// Submit and plain tick items pass through the dispatch and done states to the
// output register; segment-taking ticks also pass the segment-take state.
// A planning pass runs one division for a plain split and up to three with
// blending, all through the 44-bit serial divider.
// One item in flight; the next is taken once the result sits in the output
// register. Synchronous active-low reset empties both queues; no clear pass.
// ----------------------------------------------------------------------------
module stepper_trapezoid_planner_pulser #(
  parameter int BLOCK_QUEUE_DEPTH   = 8,
  parameter int SEGMENT_QUEUE_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  stp_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output stp_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [stp_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [stp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import stp_pkg::*;

  localparam int BIW = (BLOCK_QUEUE_DEPTH > 1) ? $clog2(BLOCK_QUEUE_DEPTH) : 1;
  localparam int BCW = $clog2(BLOCK_QUEUE_DEPTH + 1);
  localparam int SIW = (SEGMENT_QUEUE_DEPTH > 1) ? $clog2(SEGMENT_QUEUE_DEPTH) : 1;
  localparam int SCW = $clog2(SEGMENT_QUEUE_DEPTH + 1);

  typedef enum logic [16:0] {
    S_IDLE   = 17'h00001,
    S_DISP   = 17'h00002,
    S_TSEG   = 17'h00004,
    S_PBLK   = 17'h00008,
    S_PLAST  = 17'h00010,
    S_PSTART = 17'h00020,
    S_PDIVW  = 17'h00040,
    S_PSPLIT = 17'h00080,
    S_LBS    = 17'h00100,
    S_DCW    = 17'h00200,
    S_ACW    = 17'h00400,
    S_BDEC   = 17'h00800,
    S_D2S    = 17'h01000,
    S_D2W    = 17'h02000,
    S_WR     = 17'h04000,
    S_FIN    = 17'h08000,
    S_DONE   = 17'h10000
  } state_t;

  state_t state_r;

  // memories
  blk_t blk_mem [BLOCK_QUEUE_DEPTH];
  seg_t seg_mem [SEGMENT_QUEUE_DEPTH];
  blk_t blk_rd_r;
  seg_t seg_rd_r;

  logic           blk_we, blk_re;
  logic [BIW-1:0] blk_head_r, blk_tail;
  logic [BCW-1:0] blk_cnt_r;
  logic [BIW:0]   blk_sum;
  logic           seg_we, seg_re;
  logic [SIW-1:0] seg_head_r, seg_tail, seg_last, seg_raddr, seg_waddr;
  logic [SCW-1:0] seg_cnt_r;
  logic [SIW:0]   seg_sum, seg_sum1;
  seg_t           seg_wdata;

  // state
  in_item_t                in_r;
  logic                    out_valid_r;
  out_item_t               out_r;
  logic [RATE_W-1:0]       sss_r;
  logic [ACCEL_W-1:0]      accel_r;
  logic [RATE_W-1:0]       cur_r;
  logic signed [ACC_W-1:0] cacc_r;
  logic [DIST_W-1:0]       rem_r;
  logic signed [POS_W-1:0] pos_r;
  logic                    dir_r, phase_r, run_r, pin_r, drive_r, ok_r, start_r;
  logic [RATE_W-1:0]       trate_r;

  // planner working set
  blk_t                    b_r;
  seg_t                    last_r;
  logic [SIW-1:0]          last_idx_r;
  logic [RATE_W-1:0]       lbs_r;
  logic [DIV_DW-1:0]       dc_r, ac_r;
  logic signed [45:0]      prod_r;
  seg_t                    p_r [3];
  logic [1:0]              np_r, wi_r;
  logic                    rw_r;
  seg_t                    rwd_r;

  // divider
  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_num, div_quo;
  logic [DIV_DW-1:0] div_den;

  stp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // combinational helpers
  logic                    stop_req, tick_pop;
  logic [DIST_W-1:0]       rem_dec;
  logic signed [21:0]      rsum;
  logic [RATE_W-1:0]       rate_sat;
  logic signed [45:0]      lsum;
  logic [RATE_W-1:0]       lbs_sat;
  logic signed [ACC_W-1:0] a_pos, a_neg;
  logic [RATE_W-1:0]       spd_diff;
  logic [RATE_W-1:0]       lbs_diff;
  logic signed [20:0]      mul_a;
  logic signed [24:0]      mul_b;
  logic [DIV_DW-1:0]       pacc;
  logic [24:0]             dist25, dcac25;
  logic                    seg_full;
  seg_t                    new_seg;
  logic [RATE_W-1:0]       pop_rate;
  logic [DIST_W-1:0]       d2;

  assign blk_sum  = (BIW+1)'(blk_head_r) + (BIW+1)'(blk_cnt_r);
  assign blk_tail = (blk_sum >= (BIW+1)'(BLOCK_QUEUE_DEPTH)) ?
                    BIW'(blk_sum - (BIW+1)'(BLOCK_QUEUE_DEPTH)) : blk_sum[BIW-1:0];
  assign seg_sum  = (SIW+1)'(seg_head_r) + (SIW+1)'(seg_cnt_r);
  assign seg_tail = (seg_sum >= (SIW+1)'(SEGMENT_QUEUE_DEPTH)) ?
                    SIW'(seg_sum - (SIW+1)'(SEGMENT_QUEUE_DEPTH)) : seg_sum[SIW-1:0];
  assign seg_sum1 = seg_sum - 1'b1;
  assign seg_last = (seg_sum1 >= (SIW+1)'(SEGMENT_QUEUE_DEPTH)) ?
                    SIW'(seg_sum1 - (SIW+1)'(SEGMENT_QUEUE_DEPTH)) : seg_sum1[SIW-1:0];
  assign seg_full = seg_cnt_r > SCW'(SEGMENT_QUEUE_DEPTH - 3);

  assign stop_req = in_r.brake | ~in_r.enable;
  assign rem_dec  = (rem_r != '0) ? rem_r - 1'b1 : rem_r;

  assign rsum = $signed({2'b00, cur_r}) + $signed({{5{cacc_r[ACC_W-1]}}, cacc_r});
  always_comb begin
    if (rsum < 0)                          rate_sat = '0;
    else if (rsum > $signed({2'b00, RATE_MAX})) rate_sat = RATE_MAX;
    else                                   rate_sat = rsum[RATE_W-1:0];
  end

  assign lsum = prod_r + $signed({26'd0, sss_r});
  always_comb begin
    if (lsum < 0)                                lbs_sat = '0;
    else if (lsum > $signed({26'd0, RATE_MAX})) lbs_sat = RATE_MAX;
    else                                         lbs_sat = lsum[RATE_W-1:0];
  end

  assign a_pos    = $signed({1'b0, accel_r});
  assign a_neg    = -a_pos;
  assign spd_diff = (b_r.speed > sss_r) ? b_r.speed - sss_r : '0;
  assign lbs_diff = (lbs_r > b_r.speed) ? lbs_r - b_r.speed : b_r.speed - lbs_r;
  assign pacc     = div_quo[DIV_DW-1:0];
  assign dist25   = {1'b0, b_r.pulses};
  assign dcac25   = 25'(dc_r) + 25'(ac_r);
  assign d2       = div_quo[DIST_W-1:0];

  assign mul_a = (state_r == S_PLAST) ? -$signed({{4{seg_rd_r.acc[ACC_W-1]}}, seg_rd_r.acc})
                                      : $signed(dc_r);
  assign mul_b = (state_r == S_PLAST) ? $signed({1'b0, seg_rd_r.pulses})
                                      : $signed({1'b0, b_r.pulses});

  assign new_seg  = seg_rd_r;
  assign pop_rate = (dir_r == new_seg.dir) ? rate_sat : cur_r;

  assign tick_pop = (state_r == S_DISP) && (in_r.mode == MODE_TICK) && !phase_r &&
                    !stop_req && (rem_dec == '0) && (seg_cnt_r != '0);

  assign blk_we = (state_r == S_DISP) && (in_r.mode == MODE_SUBMIT) &&
                  (blk_cnt_r < BCW'(BLOCK_QUEUE_DEPTH));
  assign blk_re = (state_r == S_DISP) && (in_r.mode == MODE_PLAN) && !stop_req &&
                  (blk_cnt_r != '0);

  assign seg_re    = tick_pop || ((state_r == S_PBLK) && (seg_cnt_r != '0));
  assign seg_raddr = tick_pop ? seg_head_r : seg_last;
  assign seg_we    = (state_r == S_WR) && (rw_r || (wi_r < np_r));
  assign seg_waddr = rw_r ? last_idx_r : seg_tail;
  assign seg_wdata = rw_r ? rwd_r : p_r[wi_r];

  always_ff @(posedge clk) begin
    if (blk_we) blk_mem[blk_tail] <= '{dir: in_r.block_dir, pulses: in_r.block_distance,
                                       speed: in_r.block_speed};
    if (blk_re) blk_rd_r <= blk_mem[blk_head_r];
  end

  always_ff @(posedge clk) begin
    if (seg_we) seg_mem[seg_waddr] <= seg_wdata;
    if (seg_re) seg_rd_r <= seg_mem[seg_raddr];
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state_r)
      S_PSTART, S_LBS: begin
        div_start = 1'b1;
        div_num   = DIV_NW'(spd_diff);
        div_den   = DIV_DW'(accel_r);
      end
      S_DCW: begin
        div_start = div_done;
        div_num   = DIV_NW'(lbs_diff);
        div_den   = DIV_DW'(accel_r);
      end
      S_D2S: begin
        div_start = 1'b1;
        div_num   = prod_r[DIV_NW-1:0];
        div_den   = dc_r + ac_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_PLAST || state_r == S_BDEC) prod_r <= mul_a * mul_b;
  end

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      sss_r       <= SSS_RESET;
      accel_r     <= ACCEL_RESET;
      blk_head_r  <= '0;
      blk_cnt_r   <= '0;
      seg_head_r  <= '0;
      seg_cnt_r   <= '0;
      cur_r       <= '0;
      cacc_r      <= '0;
      rem_r       <= '0;
      pos_r       <= '0;
      dir_r       <= 1'b0;
      phase_r     <= 1'b0;
      run_r       <= 1'b0;
      pin_r       <= 1'b0;
      drive_r     <= 1'b0;
      ok_r        <= 1'b0;
      start_r     <= 1'b0;
      rw_r        <= 1'b0;
      np_r        <= '0;
      wi_r        <= '0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_START_STOP: sss_r   <= cfg_wdata[RATE_W-1:0];
          CFG_ACCEL:      accel_r <= cfg_wdata[ACCEL_W-1:0];
          default: begin
          end
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            ok_r    <= 1'b0;
            start_r <= 1'b0;
            state_r <= S_DISP;
          end
        end

        S_DISP: begin
          state_r <= tick_pop ? S_TSEG : (blk_re ? S_PBLK : S_DONE);
          unique case (in_r.mode)
            MODE_TICK: begin
              if (phase_r) begin
                pin_r   <= 1'b1;
                phase_r <= 1'b0;
                trate_r <= cur_r;
              end else begin
                pin_r   <= 1'b0;
                phase_r <= 1'b1;
                if (stop_req) begin
                  run_r      <= 1'b0;
                  cur_r      <= sss_r;
                  rem_r      <= '0;
                  trate_r    <= '0;
                  blk_head_r <= '0;
                  blk_cnt_r  <= '0;
                  seg_head_r <= '0;
                  seg_cnt_r  <= '0;
                end else begin
                  if (rem_r != '0) begin
                    pos_r <= dir_r ? pos_r + 1'b1 : pos_r - 1'b1;
                    rem_r <= rem_dec;
                  end
                  if (rem_dec == '0) begin
                    if (seg_cnt_r == '0) begin
                      run_r   <= 1'b0;
                      trate_r <= '0;
                    end
                  end else begin
                    cur_r   <= rate_sat;
                    trate_r <= rate_sat;
                  end
                end
              end
            end
            MODE_SUBMIT: begin
              if (blk_we) begin
                blk_cnt_r <= blk_cnt_r + 1'b1;
                ok_r      <= 1'b1;
              end
            end
            MODE_PLAN: begin
              drive_r <= ~stop_req;
            end
            default: begin
            end
          endcase
        end

        S_TSEG: begin
          seg_head_r <= (seg_head_r == SIW'(SEGMENT_QUEUE_DEPTH - 1)) ? '0 : seg_head_r + 1'b1;
          seg_cnt_r  <= seg_cnt_r - 1'b1;
          cur_r      <= pop_rate;
          trate_r    <= pop_rate;
          cacc_r     <= new_seg.acc;
          rem_r      <= new_seg.pulses;
          dir_r      <= new_seg.dir;
          state_r    <= S_DONE;
        end

        S_PBLK: begin
          blk_head_r <= (blk_head_r == BIW'(BLOCK_QUEUE_DEPTH - 1)) ? '0 : blk_head_r + 1'b1;
          blk_cnt_r  <= blk_cnt_r - 1'b1;
          if (seg_full || blk_rd_r.speed == '0 || (sss_r == '0 && accel_r == '0)) begin
            state_r <= S_DONE;
          end else begin
            b_r.dir    <= blk_rd_r.dir;
            b_r.pulses <= blk_rd_r.pulses;
            b_r.speed  <= (blk_rd_r.speed < sss_r) ? sss_r : blk_rd_r.speed;
            if (cur_r < sss_r) cur_r <= sss_r;
            if (sss_r == '0)   sss_r <= RATE_W'(accel_r);
            last_idx_r <= seg_last;
            state_r    <= (seg_cnt_r == '0) ? S_PSTART : S_PLAST;
          end
        end

        S_PLAST: begin
          last_r <= seg_rd_r;
          if (seg_rd_r.acc == '0 || seg_rd_r.dir != b_r.dir || b_r.speed == sss_r)
            state_r <= S_PSTART;
          else
            state_r <= S_LBS;
        end

        S_PSTART: state_r <= S_PDIVW;

        S_PDIVW: if (div_done) state_r <= S_PSPLIT;

        S_PSPLIT: begin
          rw_r <= 1'b0;
          wi_r <= '0;
          if (b_r.speed == sss_r || accel_r == '0 || pacc == '0 ||
              b_r.pulses <= DIST_W'(pacc)) begin
            p_r[0] <= '{dir: b_r.dir, acc: '0, pulses: b_r.pulses};
            np_r   <= 2'd1;
          end else if (dist25 <= 25'({pacc, 1'b0})) begin
            p_r[0] <= '{dir: b_r.dir, acc: a_pos, pulses: b_r.pulses - (b_r.pulses >> 1)};
            p_r[1] <= '{dir: b_r.dir, acc: a_neg, pulses: b_r.pulses >> 1};
            np_r   <= 2'd2;
          end else begin
            p_r[0] <= '{dir: b_r.dir, acc: a_pos, pulses: DIST_W'(pacc)};
            p_r[1] <= '{dir: b_r.dir, acc: '0,
                        pulses: DIST_W'(dist25 - 25'({pacc, 1'b0}))};
            p_r[2] <= '{dir: b_r.dir, acc: a_neg, pulses: DIST_W'(pacc)};
            np_r   <= 2'd3;
          end
          state_r <= S_WR;
        end

        S_LBS: begin
          lbs_r   <= lbs_sat;
          state_r <= S_DCW;
        end

        S_DCW: begin
          if (div_done) begin
            dc_r    <= div_quo[DIV_DW-1:0];
            state_r <= S_ACW;
          end
        end

        S_ACW: begin
          if (div_done) begin
            ac_r    <= div_quo[DIV_DW-1:0];
            state_r <= S_BDEC;
          end
        end

        S_BDEC: begin
          wi_r <= '0;
          rw_r <= 1'b1;
          if ((lbs_r < b_r.speed && dist25 <= 25'(dc_r)) ||
              (lbs_r > b_r.speed && (dist25 <= dcac25 || dc_r == '0)) ||
              (lbs_r == b_r.speed)) begin
            rwd_r   <= '{dir: b_r.dir, acc: '0, pulses: b_r.pulses};
            p_r[0]  <= last_r;
            np_r    <= 2'd1;
            state_r <= S_WR;
          end else if (lbs_r < b_r.speed && dist25 <= dcac25) begin
            state_r <= S_D2S;
          end else begin
            rwd_r  <= '{dir: last_r.dir, acc: '0, pulses: last_r.pulses};
            p_r[0] <= '{dir: b_r.dir, acc: (lbs_r < b_r.speed) ? a_pos : a_neg,
                        pulses: DIST_W'(ac_r)};
            p_r[1] <= '{dir: b_r.dir, acc: '0, pulses: DIST_W'(dist25 - dcac25)};
            p_r[2] <= '{dir: b_r.dir, acc: a_neg, pulses: DIST_W'(dc_r)};
            np_r    <= 2'd3;
            state_r <= S_WR;
          end
        end

        S_D2S: state_r <= S_D2W;

        S_D2W: begin
          if (div_done) begin
            rwd_r   <= '{dir: last_r.dir, acc: '0, pulses: last_r.pulses};
            p_r[0]  <= '{dir: b_r.dir, acc: a_pos, pulses: b_r.pulses - d2};
            p_r[1]  <= '{dir: b_r.dir, acc: a_neg, pulses: d2};
            np_r    <= 2'd2;
            state_r <= S_WR;
          end
        end

        S_WR: begin
          if (rw_r) begin
            rw_r <= 1'b0;
          end else if (wi_r < np_r) begin
            seg_cnt_r <= seg_cnt_r + 1'b1;
            wi_r      <= wi_r + 1'b1;
          end else begin
            state_r <= S_FIN;
          end
        end

        S_FIN: begin
          ok_r <= 1'b1;
          if (!run_r) begin
            cur_r   <= sss_r;
            run_r   <= 1'b1;
            start_r <= 1'b1;
          end
          state_r <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) in_r <= in_data;
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_r.pulse_level  <= pin_r;
      out_r.dir_level    <= dir_r;
      out_r.drive_enable <= drive_r;
      out_r.step_rate    <= (in_r.mode == MODE_TICK) ? trate_r : cur_r;
      out_r.running      <= run_r;
      out_r.position     <= pos_r;
      out_r.accepted     <= ok_r;
      out_r.timer_start  <= start_r;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: hw/rtl/stp_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_chk
// Port-level checks on the stepper profiler, bound to the top level.
// ----------------------------------------------------------------------------
module stp_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input stp_pkg::out_item_t out_data
);
  import stp_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.timer_start |-> out_data.running && out_data.accepted)
    else $error("timer start without running pass");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken while busy");

endmodule

bind stepper_trapezoid_planner_pulser stp_chk u_stp_chk (.*);
